FILE: design/mre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_pkg
// shared types and constants for the maze run-length expander
// ----------------------------------------------------------------------------
package mre_pkg;

  localparam int COL_W = 11;
  localparam int ROW_W = 16;
  localparam int SYM_W = 8;
  localparam int RUN_W = 6;
  localparam int IDX_W = 3;
  localparam int DAT_W = 16;

  localparam logic [COL_W-1:0] MAX_COLUMNS = 11'd1024;
  localparam logic [ROW_W-1:0] ROW_MAX     = 16'hFFFF;

  localparam logic [SYM_W-1:0] SYM_WALL = 8'h58;  // 'X'
  localparam logic [SYM_W-1:0] SYM_PATH = 8'h20;  // ' '

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_COLUMNS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_COLUMN = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_ROW    = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_COLUMN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_ROW      = 3'd4;

  typedef enum logic [2:0] {
    CELL_WALL  = 3'd0,
    CELL_PATH  = 3'd1,
    CELL_START = 3'd2,
    CELL_END   = 3'd3,
    CELL_NONE  = 3'd4
  } cell_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] columns;
    logic [COL_W-1:0] start_column;
    logic [ROW_W-1:0] start_row;
    logic [COL_W-1:0] end_column;
    logic [ROW_W-1:0] end_row;
  } cfg_regs_t;

  typedef struct packed {
    cell_res_t        code;
    logic             brk;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } cell_t;

endpackage

FILE: design/mre_cell_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mre_cell_step
// advances the position by one cell and classifies that cell
// ----------------------------------------------------------------------------
module mre_cell_step
  import mre_pkg::*;
(
  input  cfg_regs_t        cfg,
  input  logic [COL_W-1:0] column,
  input  logic [ROW_W-1:0] row,
  input  logic [SYM_W-1:0] symbol,
  output cell_t            result
);

  logic [COL_W-1:0] width;
  logic             wrap;
  logic [COL_W-1:0] col_base;
  logic [ROW_W-1:0] row_new;
  logic [COL_W-1:0] col_new;

  // width of zero acts as one, anything above the maximum is clipped
  always_comb begin
    if (cfg.columns == '0) begin
      width = COL_W'(1);
    end else if (cfg.columns > MAX_COLUMNS) begin
      width = MAX_COLUMNS;
    end else begin
      width = cfg.columns;
    end
  end

  assign wrap     = (column >= width);
  assign col_base = wrap ? '0 : column;
  assign col_new  = col_base + COL_W'(1);
  assign row_new  = (wrap && (row != ROW_MAX)) ? row + ROW_W'(1) : row;

  always_comb begin
    result.brk    = wrap;
    result.column = col_new;
    result.row    = row_new;
    if (col_new == cfg.start_column && row_new == cfg.start_row) begin
      result.code = CELL_START;
    end else if (col_new == cfg.end_column && row_new == cfg.end_row) begin
      result.code = CELL_END;
    end else if (symbol == SYM_WALL) begin
      result.code = CELL_WALL;
    end else if (symbol == SYM_PATH) begin
      result.code = CELL_PATH;
    end else begin
      result.code = CELL_NONE;
    end
  end

endmodule

FILE: design/maze_run_length_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_run_length_expander_unit
// expands run-length codewords of a maze picture into classified cells
// ----------------------------------------------------------------------------
// usage
//   input channel (in_*): one transaction is one codeword, a symbol byte and
//   a run length minus one. the block emits run_extra+1 cells on the output
//   channel (out_*), one transaction per cell, last_of_run on the final one.
//   configuration channel (cfg_*): always ready, register index 0..4 is
//   columns, start_column, start_row, end_column, end_row; other indexes are
//   dropped. write only while no codeword is in flight.
//   timing: the cell stepper produces one cell per cycle while the receiver
//   takes cells; the first cell of a codeword is registered in the output
//   register after acceptance, once the sequencer has entered its run state.
//   in_ready is low while a run is being expanded, so the next codeword is
//   taken only after the last cell of the current one has been stepped.
//   a stalled receiver simply holds the output register; the stepper waits
//   and no cell is dropped or repeated.
//   reset: position goes to column 0, row 1; registers take their defaults
//   (16 columns, no start, no end). no clearing pass is needed.
// ----------------------------------------------------------------------------
module maze_run_length_expander_unit
  import mre_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // codeword input
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic [RUN_W-1:0] in_run_extra,
  // cell output
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_cell_res,
  output logic             out_line_break_before,
  output logic [COL_W-1:0] out_cell_column,
  output logic [ROW_W-1:0] out_cell_row,
  output logic             out_last_of_run,
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [DAT_W-1:0] cfg_data
);

  // configuration registers
  cfg_regs_t cfg_r;

  // sequencer and position state
  state_t           state_r, state_nxt;
  logic [COL_W-1:0] column_r;
  logic [ROW_W-1:0] row_r;
  logic [SYM_W-1:0] symbol_r;
  logic [RUN_W-1:0] remain_r;     // cells still to emit after the current one

  // output register
  logic  out_valid_r;
  cell_t out_cell_r;
  logic  out_last_r;

  cell_t step_cell;
  logic  in_fire;
  logic  step_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns      <= COL_W'(16);
      cfg_r.start_column <= '0;
      cfg_r.start_row    <= '0;
      cfg_r.end_column   <= '0;
      cfg_r.end_row      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMNS:      cfg_r.columns      <= cfg_data[COL_W-1:0];
        REG_START_COLUMN: cfg_r.start_column <= cfg_data[COL_W-1:0];
        REG_START_ROW:    cfg_r.start_row    <= cfg_data[ROW_W-1:0];
        REG_END_COLUMN:   cfg_r.end_column   <= cfg_data[COL_W-1:0];
        REG_END_ROW:      cfg_r.end_row      <= cfg_data[ROW_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // shared stepper: wrap, advance and classify one cell
  mre_cell_step u_step (
    .cfg    (cfg_r),
    .column (column_r),
    .row    (row_r),
    .symbol (symbol_r),
    .result (step_cell)
  );

  // a cell is produced when running and the output register is free or draining
  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    step_go   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!out_valid_r || out_ready) begin
          step_go = 1'b1;
          if (remain_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position and run bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= ROW_W'(1);
      remain_r <= '0;
    end else if (in_fire) begin
      remain_r <= in_run_extra;
    end else if (step_go) begin
      column_r <= step_cell.column;
      row_r    <= step_cell.row;
      remain_r <= remain_r - RUN_W'(1);
    end
  end

  // codeword symbol held for the whole run
  always_ff @(posedge clk) begin
    if (in_fire) begin
      symbol_r <= in_symbol;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_cell_r <= step_cell;
      out_last_r <= (remain_r == '0);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_cell_res          = out_cell_r.code;
  assign out_line_break_before = out_cell_r.brk;
  assign out_cell_column       = out_cell_r.column;
  assign out_cell_row          = out_cell_r.row;
  assign out_last_of_run       = out_last_r;

endmodule
